// File: src/sas_pkg.sv
// Package for the shifting array store: codes, states, word types and defaults.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sas_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int DATA_W       = 32;

	typedef enum logic [2:0] {
		FN_GET      = 3'd0,
		FN_PUSH     = 3'd1,
		FN_APPEND   = 3'd2,
		FN_POP      = 3'd3,
		FN_TRUNCATE = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		STS_DONE  = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_GET,
		ST_SHIFT,
		ST_HEAD,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [2:0]               func;
		logic signed [DATA_W-1:0] value;
		logic [5:0]               index;
	} op_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [6:0]               count;
		logic [1:0]               status;
	} res_word_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} seq_sts_t;

endpackage

`default_nettype wire

// File: src/shifting_array_store_core.sv
// Top level of the shifting array store: handshakes, result register, sequencer and memory.
// Depends on sas_pkg, sas_mem and sas_seq.
//
//   Channel | Valid     | Stall     | Word
//   op      | op_valid  | op_stall  | op  (func, value, index)
//   res     | res_valid | res_stall | res (read_value, count, status)
//
// Get reads its slot through the registered read port; append, truncate, unused codes and
// refused words need no memory read. Pop front and push front onto a nonempty store move
// each held word through the memory read and write ports, one word at a time.
// After reset a clearing pass writes zero to all CAPACITY slots, one per cycle, with
// op_stall high. A result waits in its own register, so a stalled res channel holds up
// the sequencer only when a second result is ready.
`default_nettype none

module shifting_array_store_core #(
	parameter int CAPACITY = sas_pkg::CAPACITY_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 op_valid,
	output logic                op_stall,
	input  sas_pkg::op_word_t   op,
	output logic                res_valid,
	input  wire                 res_stall,
	output sas_pkg::res_word_t  res
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	sas_pkg::seq_sts_t          seq_sts;
	sas_pkg::res_word_t         seq_res;
	sas_pkg::mem_ctl_t          mem_ctl;
	logic [AW-1:0]              waddr, raddr;
	logic [sas_pkg::DATA_W-1:0] wdata, rdata;
	logic                       accept, out_free;
	logic                       res_valid_q;
	sas_pkg::res_word_t         res_q;

	assign op_stall = seq_sts.busy;
	assign accept   = op_valid && !op_stall;
	assign out_free = !res_valid_q || !res_stall;

	sas_seq #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.op       (op),
		.out_free (out_free),
		.sts      (seq_sts),
		.res      (seq_res),
		.mem_ctl  (mem_ctl),
		.waddr    (waddr),
		.wdata    (wdata),
		.raddr    (raddr),
		.rdata    (rdata)
	);

	sas_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (seq_sts.done) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_sts.done) begin
			res_q <= seq_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> op_stall)
		else $error("sequencer took a second word before finishing the first");

	a_full_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == sas_pkg::STS_FULL) |-> (res.read_value == '0))
		else $error("dropped insert returned a nonzero read value");

	a_empty_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == sas_pkg::STS_EMPTY) |-> (res.count == '0))
		else $error("empty status reported with a nonzero count");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |-> !seq_sts.done)
		else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// File: src/sas_mem.sv
// Slot memory of the shifting array store: one write port, one registered read port.
// Depends on sas_pkg.
`default_nettype none

module sas_mem #(
	parameter int DEPTH = sas_pkg::CAPACITY_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire                          clk,
	input  sas_pkg::mem_ctl_t            ctl,
	input  wire  [AW-1:0]                waddr,
	input  wire  [sas_pkg::DATA_W-1:0]   wdata,
	input  wire  [AW-1:0]                raddr,
	output logic [sas_pkg::DATA_W-1:0]   rdata
);

	logic [sas_pkg::DATA_W-1:0] mem [DEPTH];
	logic [sas_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: src/sas_seq.sv
// Sequencer of the shifting array store: walks the slot memory for each operation.
// Depends on sas_pkg; drives one sas_mem port pair.
`default_nettype none

module sas_seq #(
	parameter int CAPACITY = sas_pkg::CAPACITY_DEF,
	parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          accept,
	input  sas_pkg::op_word_t            op,
	input  wire                          out_free,
	output sas_pkg::seq_sts_t            sts,
	output sas_pkg::res_word_t           res,
	output sas_pkg::mem_ctl_t            mem_ctl,
	output logic [AW-1:0]                waddr,
	output logic [sas_pkg::DATA_W-1:0]   wdata,
	output logic [AW-1:0]                raddr,
	input  wire  [sas_pkg::DATA_W-1:0]   rdata
);

	sas_pkg::state_t            state_q, state_d;
	logic [2:0]                 func_q, func_d;
	logic [sas_pkg::DATA_W-1:0] value_q, value_d;
	logic [sas_pkg::DATA_W-1:0] rv_q, rv_d;
	logic [1:0]                 sts_q, sts_d;
	logic [CW-1:0]              count_q, count_d;
	logic [AW-1:0]              ptr_q, ptr_d;
	logic                       full, empty, idx_ok;

	assign full   = (count_q == CW'(CAPACITY));
	assign empty  = (count_q == '0);
	assign idx_ok = ({26'd0, op.index} < 32'(CAPACITY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sas_pkg::ST_CLEAR;
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ptr_q   <= ptr_d;
		end
	end

	always_ff @(posedge clk) begin
		func_q  <= func_d;
		value_q <= value_d;
		rv_q    <= rv_d;
		sts_q   <= sts_d;
	end

	always_comb begin
		state_d  = state_q;
		func_d   = func_q;
		value_d  = value_q;
		rv_d     = rv_q;
		sts_d    = sts_q;
		count_d  = count_q;
		ptr_d    = ptr_q;
		mem_ctl  = '0;
		waddr    = ptr_q;
		wdata    = value_q;
		raddr    = ptr_q;
		sts.busy = 1'b1;
		sts.done = 1'b0;
		case (state_q)
			sas_pkg::ST_CLEAR: begin
				mem_ctl.wr_en = 1'b1;
				wdata         = '0;
				if (ptr_q == AW'(CAPACITY - 1)) begin
					state_d = sas_pkg::ST_IDLE;
				end else begin
					ptr_d = ptr_q + AW'(1);
				end
			end
			sas_pkg::ST_IDLE: begin
				sts.busy = 1'b0;
				if (accept) begin
					func_d  = op.func;
					value_d = op.value;
					rv_d    = '0;
					sts_d   = sas_pkg::STS_DONE;
					state_d = sas_pkg::ST_FINISH;
					case (op.func)
						sas_pkg::FN_GET: begin
							if (idx_ok) begin
								mem_ctl.rd_en = 1'b1;
								raddr         = AW'(op.index);
								state_d       = sas_pkg::ST_GET;
							end
						end
						sas_pkg::FN_PUSH: begin
							if (full) begin
								sts_d = sas_pkg::STS_FULL;
							end else if (empty) begin
								mem_ctl.wr_en = 1'b1;
								waddr         = '0;
								wdata         = op.value;
								count_d       = count_q + CW'(1);
							end else begin
								mem_ctl.rd_en = 1'b1;
								raddr         = AW'(count_q - CW'(1));
								ptr_d         = AW'(count_q - CW'(1));
								state_d       = sas_pkg::ST_SHIFT;
							end
						end
						sas_pkg::FN_APPEND: begin
							if (full) begin
								sts_d = sas_pkg::STS_FULL;
							end else begin
								mem_ctl.wr_en = 1'b1;
								waddr         = AW'(count_q);
								wdata         = op.value;
								count_d       = count_q + CW'(1);
							end
						end
						sas_pkg::FN_POP: begin
							if (empty) begin
								sts_d = sas_pkg::STS_EMPTY;
							end else if (count_q == CW'(1)) begin
								count_d = '0;
							end else begin
								mem_ctl.rd_en = 1'b1;
								raddr         = AW'(1);
								ptr_d         = AW'(1);
								state_d       = sas_pkg::ST_SHIFT;
							end
						end
						sas_pkg::FN_TRUNCATE: begin
							if (empty) begin
								sts_d = sas_pkg::STS_EMPTY;
							end else begin
								count_d = count_q - CW'(1);
							end
						end
						default: begin
						end
					endcase
				end
			end
			sas_pkg::ST_GET: begin
				rv_d    = rdata;
				state_d = sas_pkg::ST_FINISH;
			end
			sas_pkg::ST_SHIFT: begin
				mem_ctl.wr_en = 1'b1;
				wdata         = rdata;
				if (func_q == sas_pkg::FN_PUSH) begin
					waddr = ptr_q + AW'(1);
					if (ptr_q != '0) begin
						mem_ctl.rd_en = 1'b1;
						raddr         = ptr_q - AW'(1);
						ptr_d         = ptr_q - AW'(1);
					end else begin
						state_d = sas_pkg::ST_HEAD;
					end
				end else begin
					waddr = ptr_q - AW'(1);
					if (ptr_q != AW'(count_q - CW'(1))) begin
						mem_ctl.rd_en = 1'b1;
						raddr         = ptr_q + AW'(1);
						ptr_d         = ptr_q + AW'(1);
					end else begin
						count_d = count_q - CW'(1);
						state_d = sas_pkg::ST_FINISH;
					end
				end
			end
			sas_pkg::ST_HEAD: begin
				mem_ctl.wr_en = 1'b1;
				waddr         = '0;
				wdata         = value_q;
				count_d       = count_q + CW'(1);
				state_d       = sas_pkg::ST_FINISH;
			end
			sas_pkg::ST_FINISH: begin
				if (out_free) begin
					sts.done = 1'b1;
					state_d  = sas_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sas_pkg::ST_IDLE;
			end
		endcase
	end

	assign res.read_value = rv_q;
	assign res.count      = 7'(count_q);
	assign res.status     = sts_q;

endmodule

`default_nettype wire
